// File: rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hrhp_pkg.sv
`default_nettype none
package hrhp_pkg;

    typedef enum logic [4:0] {
        PH_METHOD_START, PH_METHOD, PH_SP_URI, PH_URI_START, PH_URI_PATH,
        PH_SP_VER, PH_VER_TAG, PH_MAJOR, PH_MINOR, PH_REQ_LF,
        PH_HDR_START, PH_HDR_NAME, PH_SP_VAL, PH_VAL, PH_HDR_LF,
        PH_HDRS_LF, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        EV_METHOD  = 3'd0,
        EV_URI     = 3'd1,
        EV_VERSION = 3'd2,
        EV_HEADER  = 3'd3,
        EV_CLEN    = 3'd4,
        EV_BODY    = 3'd5,
        EV_ERROR   = 3'd6
    } event_t;

    localparam logic ERR_METHOD  = 1'b0;
    localparam logic ERR_REQUEST = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [31:0] TAG_HTTP = 32'h48545450;
    localparam int CLEN_LEN = 14;

    // Result packet: 3+1+16*4+32+16+1 = 117 bits, tdata padded to 120
    typedef struct packed {
        logic        error_code;
        logic [15:0] number_two;
        logic [31:0] number_one;
        logic [15:0] second_end;
        logic [15:0] second_start;
        logic [15:0] first_end;
        logic [15:0] first_start;
        logic        method_post;
        logic [2:0]  event_res;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int TDATA_BITS  = 120;

    function automatic logic [7:0] method_char(input logic post, input logic [1:0] idx);
        logic [7:0] c;
        begin
            c = 8'h00;
            if (post) begin
                case (idx)
                    2'd0: c = "P";
                    2'd1: c = "O";
                    2'd2: c = "S";
                    default: c = "T";
                endcase
            end else begin
                case (idx)
                    2'd0: c = "G";
                    2'd1: c = "E";
                    default: c = "T";
                endcase
            end
            return c;
        end
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                4'd0: c = "C";
                4'd1: c = "o";
                4'd2: c = "n";
                4'd3: c = "t";
                4'd4: c = "e";
                4'd5: c = "n";
                4'd6: c = "t";
                4'd7: c = "-";
                4'd8: c = "L";
                4'd9: c = "e";
                4'd10: c = "n";
                4'd11: c = "g";
                4'd12: c = "t";
                4'd13: c = "h";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/hrhp_front.sv
`default_nettype none
// Byte-level parse state machine; emits at most one result per byte.
module hrhp_front #(
    parameter int OFFSET_BITS = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    input  wire  [7:0]            in_byte,
    input  wire                   in_first,
    output logic                  res_valid,
    output hrhp_pkg::result_t     res_data
);

    localparam int SAT16 = 65535;

    hrhp_pkg::phase_t phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic        post_reg, post_next;
    logic [OFFSET_BITS-1:0] uri_reg, uri_next;
    logic [31:0] tag_reg, tag_next;
    logic [2:0]  tcnt_reg, tcnt_next;
    logic [15:0] major_reg, major_next;
    logic [15:0] minor_reg, minor_next;
    logic [OFFSET_BITS-1:0] nb_reg, nb_next, nf_reg, nf_next, vb_reg, vb_next, vf_reg, vf_next;
    logic [4:0]  midx_reg, midx_next;
    logic        mok_reg, mok_next;
    logic [31:0] len_reg, len_next;
    logic        lstop_reg, lstop_next;

    logic [7:0]  ch;
    logic        is_dig;
    logic [3:0]  dig;
    logic [31:0] len_base;
    logic [35:0] len_mul;
    logic [20:0] maj_mul, min_mul;

    assign ch     = in_byte;
    assign is_dig = (ch >= "0") && (ch <= "9");
    assign dig    = 4'(ch - "0");
    // A value that starts on this byte accumulates from zero.
    assign len_base = (phase_reg == hrhp_pkg::PH_SP_VAL) ? 32'd0 : len_reg;
    assign len_mul = {len_base, 3'b000} + {3'b000, len_base, 1'b0} + 36'(dig);
    assign maj_mul = {major_reg, 3'b000} + {3'b000, major_reg, 1'b0} + 21'(dig);
    assign min_mul = {minor_reg, 3'b000} + {3'b000, minor_reg, 1'b0} + 21'(dig);

    function automatic hrhp_pkg::result_t mk(input hrhp_pkg::event_t ev);
        hrhp_pkg::result_t r;
        begin
            r = '0;
            r.event_res = ev;
            return r;
        end
    endfunction

    always_comb begin
        hrhp_pkg::phase_t ph;
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] inc;
        logic [4:0] midx;
        logic mok;
        ph = phase_reg; off = offset_reg; post_next = post_reg; uri_next = uri_reg;
        tag_next = tag_reg; tcnt_next = tcnt_reg; major_next = major_reg;
        minor_next = minor_reg; nb_next = nb_reg; nf_next = nf_reg; vb_next = vb_reg;
        vf_next = vf_reg; midx = midx_reg; mok = mok_reg; len_next = len_reg;
        lstop_next = lstop_reg;
        res_valid = 1'b0;
        res_data = '0;
        if (in_first) begin
            ph = hrhp_pkg::PH_METHOD_START; off = '0; post_next = 1'b0; uri_next = '0;
            tag_next = '0; tcnt_next = '0; major_next = '0; minor_next = '0;
            nb_next = '0; nf_next = '0; vb_next = '0; vf_next = '0;
            midx = '0; mok = 1'b1; len_next = '0; lstop_next = 1'b0;
        end
        inc = off + 1'b1;
        // Pass-through phases (no byte consumed) resolve in the same cycle.
        if (ph == hrhp_pkg::PH_SP_URI && ch != hrhp_pkg::CH_SPACE)
            ph = hrhp_pkg::PH_URI_START;
        if (ph == hrhp_pkg::PH_URI_START && ch == hrhp_pkg::CH_SLASH) begin
            uri_next = off; ph = hrhp_pkg::PH_URI_PATH;
        end
        if (ph == hrhp_pkg::PH_SP_VER && ch != hrhp_pkg::CH_SPACE) begin
            tcnt_next = '0; tag_next = '0; ph = hrhp_pkg::PH_VER_TAG;
        end
        if (ph == hrhp_pkg::PH_HDR_START && ch != hrhp_pkg::CH_CR) begin
            nb_next = off; midx = '0; mok = 1'b1; ph = hrhp_pkg::PH_HDR_NAME;
        end
        if (ph == hrhp_pkg::PH_SP_VAL && ch != hrhp_pkg::CH_SPACE) begin
            vb_next = off; len_next = '0; lstop_next = 1'b0; ph = hrhp_pkg::PH_VAL;
        end
        phase_next = ph;
        offset_next = off;
        midx_next = midx;
        mok_next = mok;
        if (in_valid) begin
            unique case (ph)
                hrhp_pkg::PH_METHOD_START: begin
                    if (ch == "G" || ch == "P") begin
                        post_next = (ch == "P"); offset_next = inc;
                        phase_next = hrhp_pkg::PH_METHOD;
                    end else begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_METHOD;
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                hrhp_pkg::PH_METHOD: begin
                    if (off >= OFFSET_BITS'(post_reg ? 4 : 3)) begin
                        offset_next = inc; res_valid = 1'b1;
                        res_data = mk(hrhp_pkg::EV_METHOD);
                        res_data.method_post = post_reg;
                        phase_next = hrhp_pkg::PH_SP_URI;
                    end else if (ch == hrhp_pkg::method_char(post_reg, off[1:0])) begin
                        offset_next = inc;
                    end else begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_METHOD;
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                hrhp_pkg::PH_SP_URI, hrhp_pkg::PH_SP_VER, hrhp_pkg::PH_SP_VAL:
                    offset_next = inc;
                hrhp_pkg::PH_URI_START: begin
                    res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                    res_data.error_code = hrhp_pkg::ERR_REQUEST;
                    phase_next = hrhp_pkg::PH_DONE;
                end
                hrhp_pkg::PH_URI_PATH: begin
                    if (ch == hrhp_pkg::CH_SPACE) begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_URI);
                        res_data.first_start = 16'(uri_next);
                        res_data.first_end = 16'(off);
                        phase_next = hrhp_pkg::PH_SP_VER;
                    end
                    offset_next = inc;
                end
                hrhp_pkg::PH_VER_TAG: begin
                    if (tcnt_next < 3'd4) begin
                        tag_next = {tag_next[23:0], ch};
                        tcnt_next = tcnt_next + 3'd1;
                        offset_next = inc;
                    end else if (tag_reg != hrhp_pkg::TAG_HTTP || ch != hrhp_pkg::CH_SLASH) begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_REQUEST;
                        phase_next = hrhp_pkg::PH_DONE;
                    end else begin
                        major_next = '0; minor_next = '0;
                        phase_next = hrhp_pkg::PH_MAJOR; offset_next = inc;
                    end
                end
                hrhp_pkg::PH_MAJOR: begin
                    if (ch == hrhp_pkg::CH_DOT) begin
                        phase_next = hrhp_pkg::PH_MINOR; offset_next = inc;
                    end else if (is_dig) begin
                        major_next = (maj_mul > 21'(SAT16)) ? 16'hFFFF : maj_mul[15:0];
                        offset_next = inc;
                    end else begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_REQUEST;
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                hrhp_pkg::PH_MINOR: begin
                    if (ch == hrhp_pkg::CH_CR) begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_VERSION);
                        res_data.number_one = {16'h0, major_reg};
                        res_data.number_two = minor_reg;
                        phase_next = hrhp_pkg::PH_REQ_LF; offset_next = inc;
                    end else if (is_dig) begin
                        minor_next = (min_mul > 21'(SAT16)) ? 16'hFFFF : min_mul[15:0];
                        offset_next = inc;
                    end else begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_REQUEST;
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                hrhp_pkg::PH_REQ_LF: begin
                    if (ch == hrhp_pkg::CH_LF) begin
                        phase_next = hrhp_pkg::PH_HDR_START; offset_next = inc;
                    end else begin
                        res_valid = 1'b1; res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_REQUEST;
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                hrhp_pkg::PH_HDR_START: begin
                    phase_next = hrhp_pkg::PH_HDRS_LF; offset_next = inc;
                end
                hrhp_pkg::PH_HDR_NAME: begin
                    if (ch == hrhp_pkg::CH_COLON) begin
                        nf_next = off; phase_next = hrhp_pkg::PH_SP_VAL;
                    end else if (mok && midx < 5'(hrhp_pkg::CLEN_LEN)
                                 && ch == hrhp_pkg::clen_char(midx[3:0])) begin
                        midx_next = midx + 5'd1;
                    end else begin
                        mok_next = 1'b0;
                    end
                    offset_next = inc;
                end
                hrhp_pkg::PH_VAL: begin
                    if (ch == hrhp_pkg::CH_CR) begin
                        vf_next = off; phase_next = hrhp_pkg::PH_HDR_LF;
                    end else if (!lstop_next && is_dig) begin
                        len_next = (len_mul[35:32] != 4'd0) ? 32'hFFFFFFFF : len_mul[31:0];
                    end else begin
                        lstop_next = 1'b1;
                    end
                    offset_next = inc;
                end
                hrhp_pkg::PH_HDR_LF: begin
                    res_valid = 1'b1;
                    if (ch == hrhp_pkg::CH_LF) begin
                        offset_next = inc; phase_next = hrhp_pkg::PH_HDR_START;
                        if (mok && midx == 5'(hrhp_pkg::CLEN_LEN)) begin
                            res_data = mk(hrhp_pkg::EV_CLEN);
                            res_data.number_one = len_reg;
                        end else begin
                            res_data = mk(hrhp_pkg::EV_HEADER);
                            res_data.first_start = 16'(nb_reg);
                            res_data.first_end = 16'(nf_reg);
                            res_data.second_start = 16'(vb_reg);
                            res_data.second_end = 16'(vf_reg);
                        end
                    end else begin
                        res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_REQUEST;
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                hrhp_pkg::PH_HDRS_LF: begin
                    res_valid = 1'b1;
                    if (ch == hrhp_pkg::CH_LF) begin
                        offset_next = inc;
                        res_data = mk(hrhp_pkg::EV_BODY);
                        res_data.first_start = 16'(inc);
                    end else begin
                        res_data = mk(hrhp_pkg::EV_ERROR);
                        res_data.error_code = hrhp_pkg::ERR_REQUEST;
                    end
                    phase_next = hrhp_pkg::PH_DONE;
                end
                default: phase_next = hrhp_pkg::PH_DONE;
            endcase
        end else begin
            phase_next = phase_reg; offset_next = offset_reg; post_next = post_reg;
            uri_next = uri_reg; tag_next = tag_reg; tcnt_next = tcnt_reg;
            major_next = major_reg; minor_next = minor_reg; nb_next = nb_reg;
            nf_next = nf_reg; vb_next = vb_reg; vf_next = vf_reg; midx_next = midx_reg;
            mok_next = mok_reg; len_next = len_reg; lstop_next = lstop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hrhp_pkg::PH_METHOD_START;
            offset_reg <= '0; post_reg <= 1'b0; uri_reg <= '0; tag_reg <= '0;
            tcnt_reg <= '0; major_reg <= '0; minor_reg <= '0; nb_reg <= '0;
            nf_reg <= '0; vb_reg <= '0; vf_reg <= '0; midx_reg <= '0;
            mok_reg <= 1'b1; len_reg <= '0; lstop_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; offset_reg <= offset_next; post_reg <= post_next;
            uri_reg <= uri_next; tag_reg <= tag_next; tcnt_reg <= tcnt_next;
            major_reg <= major_next; minor_reg <= minor_next; nb_reg <= nb_next;
            nf_reg <= nf_next; vb_reg <= vb_next; vf_reg <= vf_next;
            midx_reg <= midx_next; mok_reg <= mok_next; len_reg <= len_next;
            lstop_reg <= lstop_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/hrhp_queue.sv
`default_nettype none
// Four-entry result queue between the parser and the output port.
module hrhp_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                wr_en,
    input  hrhp_pkg::result_t  wr_data,
    output logic               almost_full,
    output logic               rd_valid,
    output hrhp_pkg::result_t  rd_data,
    input  wire                rd_en
);

    hrhp_pkg::result_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    // Keep one slot spare so a transaction accepted this cycle always fits.
    assign almost_full = (cnt_reg >= 3'd3);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en && rd_valid) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_en) - 3'(rd_en && rd_valid);
        end
    end

endmodule
`default_nettype wire

// File: rtl/hrhp_back.sv
`default_nettype none
// Output register stage driving the master channel.
module hrhp_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                q_valid,
    input  hrhp_pkg::result_t  q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [hrhp_pkg::TDATA_BITS-1:0] m_tdata
);

    logic valid_reg;
    hrhp_pkg::result_t data_reg;

    assign q_pop = q_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata = {(hrhp_pkg::TDATA_BITS - hrhp_pkg::RESULT_BITS)'(0), data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (q_pop) valid_reg <= 1'b1;
        else if (m_tready) valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) data_reg <= q_data;
    end

endmodule
`default_nettype wire

// File: rtl/http_request_head_parser_unit.sv
`default_nettype none
// HTTP request head parser. Takes one request byte per transaction on s_ with
// s_tuser marking the first byte of a request, and emits at most one event per
// byte on m_. One byte per cycle while s_tready is high: the byte-level state
// machine produces its result combinationally and feeds a four-entry result
// queue, then an output register. s_tready drops only while the queue is nearly full.
module http_request_head_parser_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] data_byte
    input  wire          s_tuser,   // [0] first_byte
    output logic         m_tvalid,
    input  wire          m_tready,
    // [2:0] event_res, [3] method_post, [19:4] first_start, [35:20] first_end,
    // [51:36] second_start, [67:52] second_end, [99:68] number_one,
    // [115:100] number_two, [116] error_code, [119:117] zero
    output logic [119:0] m_tdata
);

    logic res_valid, q_full, q_valid, q_pop;
    hrhp_pkg::result_t res_data, q_data;

    assign s_tready = !q_full;

    hrhp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid && s_tready),
        .in_byte(s_tdata), .in_first(s_tuser),
        .res_valid(res_valid), .res_data(res_data)
    );

    hrhp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(res_valid), .wr_data(res_data),
        .almost_full(q_full), .rd_valid(q_valid), .rd_data(q_data), .rd_en(q_pop)
    );

    hrhp_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/hrhp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module hrhp_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [119:0] m_tdata
);
    `ASSERT_IMPL(a_event_range, aclk, aresetn, m_tvalid, m_tdata[2:0] != 3'd7, "bad event")
    `ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[119:117] == 3'd0, "pad set")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "valid dropped")
    `ASSERT_IMPL(a_clen_no_off, aclk, aresetn, m_tvalid && m_tdata[2:0] == hrhp_pkg::EV_CLEN,
        m_tdata[67:4] == 64'd0, "offsets on length event")
endmodule

bind http_request_head_parser_unit hrhp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
